// File: hdl/lomt_pkg.sv
// ----------------------------------------------------------------------------
// lomt_pkg: shared types and constants for the one-shot modifier tracker
// Keycode widths, slot phase codes, result action codes and the structs
// that pass between the sequencer and the shared slot unit.
// ----------------------------------------------------------------------------
package lomt_pkg;

  localparam int unsigned KEY_W   = 16;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PHASE_W = 3;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [TIME_W-1:0] ms_t;
  typedef logic [PHASE_W-1:0] phase_t;

  // Slot phases
  localparam phase_t PH_UP_UNQ    = 3'd0;
  localparam phase_t PH_UP_Q      = 3'd1;
  localparam phase_t PH_UP_QU     = 3'd2;
  localparam phase_t PH_DN_UNUSED = 3'd3;
  localparam phase_t PH_DN_USED   = 3'd4;

  // Configuration register indexes (0..3 are the slot key pairs)
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUED_TIMEOUT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_WAIT      = 3'd5;

  localparam ms_t TIMEOUT_RESET = 16'd500;

  // HID modifier keycode range
  localparam key_t HID_MOD_LO = 16'h00E0;
  localparam key_t HID_MOD_HI = 16'h00E7;

  typedef enum logic [1:0] {
    ACT_DONE    = 2'd0,
    ACT_PRESS   = 2'd1,
    ACT_RELEASE = 2'd2
  } action_e;

  // Item-wide context for the slot unit
  typedef struct packed {
    logic scan;
    logic press;
    logic any_trig;
    logic ignored;
    ms_t  now;
    ms_t  queued_timeout;
    ms_t  hold_wait;
  } ctrl_t;

  // One slot's state as seen by the slot unit
  typedef struct packed {
    phase_t phase;
    logic   mod_held;
    logic   armed;
    ms_t    queued_since;
    ms_t    pressed_since;
    logic   trig;
    logic   trig_press;
  } slot_in_t;

  // Updated slot state and the result it emits, if any
  typedef struct packed {
    phase_t  phase;
    logic    armed;
    ms_t     queued_since;
    ms_t     pressed_since;
    logic    emit;
    action_e act;
  } slot_out_t;

endpackage

// File: hdl/lomt_if.sv
// ----------------------------------------------------------------------------
// lomt_in_if / lomt_out_if: valid-ready channels of the tracker
// The input channel carries key events and scan ticks; the output channel
// carries press, release and done results.
// ----------------------------------------------------------------------------
interface lomt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [lomt_pkg::KEY_W-1:0]   key_code;
  logic                         is_press;
  logic [lomt_pkg::TIME_W-1:0]  now_ms;

  modport source (output valid, output operation, output key_code,
                  output is_press, output now_ms, input ready);
  modport sink   (input valid, input operation, input key_code,
                  input is_press, input now_ms, output ready);
endinterface

interface lomt_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic [lomt_pkg::KEY_W-1:0]   mod_code;
  logic                         pass_key;
  logic                         last;

  modport source (output valid, output action, output mod_code,
                  output pass_key, output last, input ready);
  modport sink   (input valid, input action, input mod_code,
                  input pass_key, input last, output ready);
endinterface

// File: hdl/lomt_slot_unit.sv
// ----------------------------------------------------------------------------
// lomt_slot_unit: shared per-slot step of the one-shot machine
// Applied to one slot per cycle unless stalled. Holds the single elapsed-time
// subtract and threshold compare; gives the slot's next phase and result.
// ----------------------------------------------------------------------------
module lomt_slot_unit (
  input  lomt_pkg::ctrl_t    ctrl_i,
  input  lomt_pkg::slot_in_t slot_i,
  output lomt_pkg::slot_out_t slot_o
);
  import lomt_pkg::*;

  ms_t  stamp;
  ms_t  limit;
  ms_t  elapsed;
  logic over;

  // Shared elapsed-time unit: scans look at the queue stamp, keys at the hold
  assign stamp   = ctrl_i.scan ? slot_i.queued_since : slot_i.pressed_since;
  assign limit   = ctrl_i.scan ? ctrl_i.queued_timeout : ctrl_i.hold_wait;
  assign elapsed = ctrl_i.now - stamp;
  assign over    = elapsed > limit;

  always_comb begin
    slot_o.phase         = slot_i.phase;
    slot_o.armed         = slot_i.armed;
    slot_o.queued_since  = slot_i.queued_since;
    slot_o.pressed_since = slot_i.pressed_since;
    slot_o.emit          = 1'b0;
    slot_o.act           = ACT_RELEASE;

    if (ctrl_i.scan) begin
      // Queued modifier timed out
      if (slot_i.armed && over) begin
        slot_o.armed = 1'b0;
        slot_o.phase = PH_UP_UNQ;
        slot_o.emit  = 1'b1;
      end
    end else if (slot_i.trig) begin
      if (slot_i.trig_press) begin
        if (slot_i.phase == PH_UP_UNQ) begin
          slot_o.emit = 1'b1;
          slot_o.act  = ACT_PRESS;
        end
        slot_o.pressed_since = ctrl_i.now;
        slot_o.phase         = PH_DN_UNUSED;
      end else if (slot_i.phase == PH_DN_UNUSED && !slot_i.mod_held) begin
        // Long hold releases, short tap queues a one-shot
        if (over) begin
          slot_o.phase = PH_UP_UNQ;
          slot_o.emit  = 1'b1;
        end else begin
          slot_o.phase        = PH_UP_Q;
          slot_o.armed        = 1'b1;
          slot_o.queued_since = ctrl_i.now;
        end
      end else if (slot_i.phase == PH_DN_USED && !slot_i.mod_held) begin
        slot_o.phase = PH_UP_UNQ;
        slot_o.emit  = 1'b1;
      end
    end else if (!ctrl_i.any_trig && !ctrl_i.ignored) begin
      // Other keys consume or release a queued modifier, or mark a down one used
      if (ctrl_i.press) begin
        if (slot_i.phase == PH_UP_Q) begin
          slot_o.phase = PH_UP_QU;
          slot_o.armed = 1'b0;
        end else if (slot_i.phase == PH_UP_QU) begin
          slot_o.phase = PH_UP_UNQ;
          slot_o.emit  = 1'b1;
        end
      end else begin
        if (slot_i.phase == PH_DN_UNUSED) begin
          slot_o.phase = PH_DN_USED;
        end else if (slot_i.phase == PH_UP_Q || slot_i.phase == PH_UP_QU) begin
          slot_o.phase = PH_UP_UNQ;
          slot_o.emit  = 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/layer_oneshot_mod_tracker.sv
// ----------------------------------------------------------------------------
// layer_oneshot_mod_tracker: layer-gated one-shot modifier tracker
// Up to FLOW_SLOTS slots pair a layer key with a modifier key. Key events and
// scan ticks step each slot's one-shot machine; results are press/release
// modifier items followed by a done item carrying the pass flag.
//
//   channel   dir  handshake        payload
//   in_i      in   valid/ready      operation, key_code, is_press, now_ms
//   out_o     out  valid/ready      action, mod_code, pass_key, last
//   cfg       in   cfg_we_i         cfg_idx_i, cfg_data_i (no back-pressure)
//
// A key event runs from the accept through a match of the key against all
// slots, a step of each slot in turn through the shared slot unit, and the
// issue of done. A scan tick skips the match step. Reset is asynchronous;
// all slots return to up-unqueued, timeouts to 500. A held output register
// stalls the slot walk when a slot has a result, and holds back the done
// item until it drains.
// ----------------------------------------------------------------------------
module layer_oneshot_mod_tracker #(
  parameter int unsigned FLOW_SLOTS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lomt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lomt_pkg::CFG_W-1:0]        cfg_data_i,
  lomt_in_if.sink                           in_i,
  lomt_out_if.source                        out_o
);
  import lomt_pkg::*;

  localparam int unsigned SlotW = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(FLOW_SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_SLOT = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  // Configuration
  logic [CFG_W-1:0] keys_q [FLOW_SLOTS];
  ms_t              qto_q;
  ms_t              hold_q;

  // Slot state
  phase_t                phase_q [FLOW_SLOTS];
  ms_t                   qsince_q [FLOW_SLOTS];
  ms_t                   psince_q [FLOW_SLOTS];
  logic [FLOW_SLOTS-1:0] layer_held_q;
  logic [FLOW_SLOTS-1:0] mod_held_q;
  logic [FLOW_SLOTS-1:0] armed_q;

  // Item context
  state_e                state_q, state_d;
  logic [SlotW-1:0]      slot_q;
  logic                  scan_q;
  logic                  press_q;
  key_t                  kc_q;
  ms_t                   now_q;
  logic [FLOW_SLOTS-1:0] trig_q;
  logic [FLOW_SLOTS-1:0] trig_press_q;
  logic                  any_q;
  logic                  ign_q;

  // Output register
  logic    out_vld_q;
  action_e out_act_q;
  key_t    out_code_q;
  logic    out_pass_q;
  logic    out_last_q;

  logic                  in_acc;
  logic                  out_free;
  logic                  step_go;
  logic                  done_go;
  logic [FLOW_SLOTS-1:0] ev_layer_held;
  logic [FLOW_SLOTS-1:0] ev_mod_held;
  logic [FLOW_SLOTS-1:0] ev_trig;
  logic [FLOW_SLOTS-1:0] ev_trig_press;
  logic                  ev_ign;
  ctrl_t                 ctrl;
  slot_in_t              slot_in;
  slot_out_t             slot_out;
  key_t                  cur_mod;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;

  // Key match against every slot at once (independent per slot)
  always_comb begin
    ev_ign = (kc_q >= HID_MOD_LO) && (kc_q <= HID_MOD_HI);
    for (int s = 0; s < FLOW_SLOTS; s++) begin
      ev_layer_held[s] = layer_held_q[s];
      ev_mod_held[s]   = mod_held_q[s];
      ev_trig[s]       = 1'b0;
      ev_trig_press[s] = 1'b0;
      if (kc_q == keys_q[s][KEY_W-1:0]) begin
        ev_ign           = 1'b1;
        ev_layer_held[s] = press_q;
      end else if (kc_q == keys_q[s][CFG_W-1:KEY_W]) begin
        if (press_q) begin
          if (layer_held_q[s]) begin
            ev_mod_held[s]   = 1'b1;
            ev_trig[s]       = 1'b1;
            ev_trig_press[s] = 1'b1;
          end
        end else if (mod_held_q[s]) begin
          ev_mod_held[s] = 1'b0;
          if (layer_held_q[s] || phase_q[s] == PH_DN_UNUSED ||
              phase_q[s] == PH_DN_USED) begin
            ev_trig[s] = 1'b1;
          end
        end
      end
    end
  end

  // Shared slot unit, fed with the slot under the walk pointer
  assign ctrl = '{scan: scan_q, press: press_q, any_trig: any_q, ignored: ign_q,
                  now: now_q, queued_timeout: qto_q, hold_wait: hold_q};
  assign slot_in = '{phase: phase_q[slot_q], mod_held: mod_held_q[slot_q],
                     armed: armed_q[slot_q], queued_since: qsince_q[slot_q],
                     pressed_since: psince_q[slot_q], trig: trig_q[slot_q],
                     trig_press: trig_press_q[slot_q]};
  assign cur_mod = keys_q[slot_q][CFG_W-1:KEY_W];

  lomt_slot_unit u_slot (
    .ctrl_i (ctrl),
    .slot_i (slot_in),
    .slot_o (slot_out)
  );

  assign step_go = (state_q == S_SLOT) && (!slot_out.emit || out_free);
  assign done_go = (state_q == S_DONE) && out_free;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = in_i.operation ? S_SLOT : S_EVAL;
      S_EVAL: state_d = S_SLOT;
      S_SLOT: if (step_go && slot_q == LastSlot) state_d = S_DONE;
      S_DONE: if (done_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);

  // Control, configuration and slot state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      slot_q       <= '0;
      qto_q        <= TIMEOUT_RESET;
      hold_q       <= TIMEOUT_RESET;
      layer_held_q <= '0;
      mod_held_q   <= '0;
      armed_q      <= '0;
      trig_q       <= '0;
      trig_press_q <= '0;
      any_q        <= 1'b0;
      ign_q        <= 1'b0;
      out_vld_q    <= 1'b0;
      for (int s = 0; s < FLOW_SLOTS; s++) begin
        keys_q[s]   <= '0;
        phase_q[s]  <= PH_UP_UNQ;
        qsince_q[s] <= '0;
        psince_q[s] <= '0;
      end
    end else begin
      state_q <= state_d;

      // Register writes
      if (cfg_we_i) begin
        for (int s = 0; s < FLOW_SLOTS; s++) begin
          if (cfg_idx_i == CFG_IDX_W'(s)) keys_q[s] <= cfg_data_i;
        end
        if (cfg_idx_i == CFG_QUEUED_TIMEOUT) qto_q <= cfg_data_i[TIME_W-1:0];
        if (cfg_idx_i == CFG_HOLD_WAIT) hold_q <= cfg_data_i[TIME_W-1:0];
      end

      if (in_acc) begin
        slot_q <= '0;
        any_q  <= 1'b0;
        ign_q  <= 1'b0;
        trig_q <= '0;
      end

      // Match results
      if (state_q == S_EVAL) begin
        layer_held_q <= ev_layer_held;
        mod_held_q   <= ev_mod_held;
        trig_q       <= ev_trig;
        trig_press_q <= ev_trig_press;
        any_q        <= |ev_trig;
        ign_q        <= ev_ign;
      end

      // Slot walk
      if (step_go) begin
        phase_q[slot_q]  <= slot_out.phase;
        armed_q[slot_q]  <= slot_out.armed;
        qsince_q[slot_q] <= slot_out.queued_since;
        psince_q[slot_q] <= slot_out.pressed_since;
        if (slot_q != LastSlot) slot_q <= slot_q + 1'b1;
      end

      // Output valid
      if ((step_go && slot_out.emit) || done_go) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
    end
  end

  // Item capture and output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      scan_q  <= in_i.operation;
      press_q <= in_i.is_press;
      kc_q    <= in_i.key_code;
      now_q   <= in_i.now_ms;
    end
    if (step_go && slot_out.emit) begin
      out_act_q  <= slot_out.act;
      out_code_q <= cur_mod;
      out_pass_q <= 1'b0;
      out_last_q <= 1'b0;
    end else if (done_go) begin
      out_act_q  <= ACT_DONE;
      out_code_q <= '0;
      out_pass_q <= !scan_q && !any_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.action   = out_act_q;
  assign out_o.mod_code = out_code_q;
  assign out_o.pass_key = out_pass_q;
  assign out_o.last     = out_last_q;

  // Checks
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SLOT |-> slot_q <= LastSlot)
    else $error("slot pointer beyond last slot");

  a_last_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((out_act_q == ACT_DONE) == out_last_q))
    else $error("last flag does not match done action");

  a_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_go |=> out_vld_q && out_last_q && state_q == S_IDLE)
    else $error("done item not issued on leaving the walk");

  a_mid_no_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_last_q |-> !out_pass_q && out_act_q != ACT_DONE)
    else $error("modifier item carries pass flag");

endmodule

// File: dv/layer_oneshot_mod_tracker_tb.sv
// ----------------------------------------------------------------------------
// layer_oneshot_mod_tracker_tb: self-checking bench for the one-shot tracker
// Drives key events and scan ticks through the input channel, runs a
// cycle-free model of the slot machines on every accepted item and checks
// each press, release and done result against the oldest prediction.
// Directed sequences cover taps, long holds, used releases, ignored keys and
// queued timeouts across the time wrap; random traffic then runs under
// several key and threshold settings with gaps and back-pressure.
// ----------------------------------------------------------------------------
module layer_oneshot_mod_tracker_tb;
  import lomt_pkg::*;

  localparam int NSLOTS = 4;
  localparam int CYCLE_LIMIT = 200000;

  // Operation codes of an input item
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  // Slot key pair register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT0_KEYS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT1_KEYS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT2_KEYS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT3_KEYS = 3'd3;

  // Register indexes past the last register; writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  // Keycodes used by the directed sequences
  localparam key_t KC_A      = 16'h0004;
  localparam key_t KC_LAYER0 = 16'h5100;
  localparam key_t KC_MOD0   = 16'h00E1;
  localparam key_t KC_LAYER1 = 16'h5101;
  localparam key_t KC_MOD1   = 16'h00E5;
  localparam key_t KC_TWIN   = 16'h5103;
  localparam key_t KC_HID    = 16'h00E3;

  typedef struct packed {
    action_e act;
    key_t    mod_code;
    logic    pass_key;
    logic    last;
  } mod_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  lomt_in_if  key_ch ();
  lomt_out_if res_ch ();

  layer_oneshot_mod_tracker #(.FLOW_SLOTS(NSLOTS)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (key_ch),
    .out_o      (res_ch)
  );

  // Model copy of configuration and per-slot state
  logic [CFG_W-1:0] slot_keys [NSLOTS];
  ms_t              queued_limit;
  ms_t              hold_limit;
  phase_t           slot_ph [NSLOTS];
  logic             layer_dn [NSLOTS];
  logic             mod_dn [NSLOTS];
  logic             armed [NSLOTS];
  ms_t              queued_at [NSLOTS];
  ms_t              pressed_at [NSLOTS];

  mod_result_t pending_results [$];
  mod_result_t oldest_result;
  bit          key_down [key_t];
  ms_t         t_ms;
  int          mismatches;
  int          cycle_cnt;
  int          rx_stall;
  int          rx_hold_req;
  bit          gaps_on;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: run limit reached", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void tracker_reset();
    for (int s = 0; s < NSLOTS; s++) begin
      slot_keys[s] = '0;
      slot_ph[s] = PH_UP_UNQ;
      layer_dn[s] = 1'b0;
      mod_dn[s] = 1'b0;
      armed[s] = 1'b0;
      queued_at[s] = '0;
      pressed_at[s] = '0;
    end
    queued_limit = TIMEOUT_RESET;
    hold_limit = TIMEOUT_RESET;
  endfunction

  function automatic void tracker_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    if (idx < CFG_QUEUED_TIMEOUT) slot_keys[idx[1:0]] = data;
    else if (idx == CFG_QUEUED_TIMEOUT) queued_limit = data[TIME_W-1:0];
    else if (idx == CFG_HOLD_WAIT) hold_limit = data[TIME_W-1:0];
  endfunction

  function automatic void push_result(action_e act, key_t code, logic pass, logic fin);
    mod_result_t r;
    r.act = act;
    r.mod_code = code;
    r.pass_key = pass;
    r.last = fin;
    pending_results.push_back(r);
  endfunction

  // Steps every slot machine on one item and queues the results it causes
  function automatic void step_tracker(logic op, key_t kc, logic press, ms_t now);
    logic   hit [NSLOTS];
    logic   hit_press [NSLOTS];
    logic   any_hit;
    logic   ign;
    logic   pass;
    phase_t ph;
    key_t   mk;

    if (op == OP_SCAN) begin
      for (int s = 0; s < NSLOTS; s++) begin
        if (armed[s] && ms_t'(now - queued_at[s]) > queued_limit) begin
          armed[s] = 1'b0;
          slot_ph[s] = PH_UP_UNQ;
          push_result(ACT_RELEASE, slot_keys[s][31:16], 1'b0, 1'b0);
        end
      end
      push_result(ACT_DONE, '0, 1'b0, 1'b1);
      return;
    end

    pass = 1'b1;
    any_hit = 1'b0;
    ign = (kc >= HID_MOD_LO && kc <= HID_MOD_HI);
    for (int s = 0; s < NSLOTS; s++)
      if (kc == slot_keys[s][15:0]) ign = 1'b1;

    // Match the key against each slot's layer and modifier key
    for (int s = 0; s < NSLOTS; s++) begin
      hit[s] = 1'b0;
      hit_press[s] = 1'b0;
      if (kc == slot_keys[s][15:0]) begin
        layer_dn[s] = press;
      end else if (kc == slot_keys[s][31:16]) begin
        if (press) begin
          if (layer_dn[s]) begin
            mod_dn[s] = 1'b1;
            hit[s] = 1'b1;
            hit_press[s] = 1'b1;
            any_hit = 1'b1;
            pass = 1'b0;
          end
        end else if (mod_dn[s]) begin
          mod_dn[s] = 1'b0;
          if (layer_dn[s] || slot_ph[s] == PH_DN_UNUSED || slot_ph[s] == PH_DN_USED) begin
            hit[s] = 1'b1;
            any_hit = 1'b1;
            pass = 1'b0;
          end
        end
      end
    end

    // Phase transitions, in slot order
    for (int s = 0; s < NSLOTS; s++) begin
      ph = slot_ph[s];
      mk = slot_keys[s][31:16];
      if (hit[s]) begin
        if (hit_press[s]) begin
          if (ph == PH_UP_UNQ) push_result(ACT_PRESS, mk, 1'b0, 1'b0);
          pressed_at[s] = now;
          slot_ph[s] = PH_DN_UNUSED;
        end else if (ph == PH_DN_UNUSED && !mod_dn[s]) begin
          if (ms_t'(now - pressed_at[s]) > hold_limit) begin
            slot_ph[s] = PH_UP_UNQ;
            push_result(ACT_RELEASE, mk, 1'b0, 1'b0);
          end else begin
            slot_ph[s] = PH_UP_Q;
            armed[s] = 1'b1;
            queued_at[s] = now;
          end
        end else if (ph == PH_DN_USED && !mod_dn[s]) begin
          slot_ph[s] = PH_UP_UNQ;
          push_result(ACT_RELEASE, mk, 1'b0, 1'b0);
        end
      end else if (!any_hit && !ign) begin
        if (press) begin
          if (ph == PH_UP_Q) begin
            slot_ph[s] = PH_UP_QU;
            armed[s] = 1'b0;
          end else if (ph == PH_UP_QU) begin
            slot_ph[s] = PH_UP_UNQ;
            push_result(ACT_RELEASE, mk, 1'b0, 1'b0);
          end
        end else begin
          if (ph == PH_DN_UNUSED) begin
            slot_ph[s] = PH_DN_USED;
          end else if (ph == PH_UP_Q || ph == PH_UP_QU) begin
            slot_ph[s] = PH_UP_UNQ;
            push_result(ACT_RELEASE, mk, 1'b0, 1'b0);
          end
        end
      end
    end
    push_result(ACT_DONE, '0, pass, 1'b1);
  endfunction

  // Result receiver: random stall bursts plus long hold-offs on request
  always @(negedge clk_i) begin
    if (rx_hold_req > 0) begin
      rx_stall = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_stall > 0) begin
      rx_stall--;
      res_ch.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      rx_stall = $urandom_range(0, 5);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: actual act=%0d mod=%h pass=%b last=%b",
                 $time, res_ch.action, res_ch.mod_code, res_ch.pass_key, res_ch.last);
      end else begin
        oldest_result = pending_results.pop_front();
        if (res_ch.action !== oldest_result.act ||
            res_ch.mod_code !== oldest_result.mod_code ||
            res_ch.pass_key !== oldest_result.pass_key ||
            res_ch.last !== oldest_result.last) begin
          mismatches++;
          $display("%0t: expected act=%0d mod=%h pass=%b last=%b", $time,
                   oldest_result.act, oldest_result.mod_code,
                   oldest_result.pass_key, oldest_result.last);
          $display("%0t: actual   act=%0d mod=%h pass=%b last=%b", $time,
                   res_ch.action, res_ch.mod_code, res_ch.pass_key, res_ch.last);
        end
      end
    end
  end

  // Sends one item; entered and left at a falling edge
  task automatic send_item(logic op, key_t kc, logic press, ms_t now);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      key_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    key_ch.valid <= 1'b1;
    key_ch.operation <= op;
    key_ch.key_code <= kc;
    key_ch.is_press <= press;
    key_ch.now_ms <= now;
    do @(posedge clk_i); while (!key_ch.ready);
    step_tracker(op, kc, press, now);
    @(negedge clk_i);
  endtask

  task automatic wait_results_drained();
    key_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (NSLOTS + 6) @(negedge clk_i);
  endtask

  // Register write; only issued while the block is idle
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    tracker_config(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_random_slots(bit wide_keys);
    key_t lk;
    key_t mk;
    for (int s = 0; s < NSLOTS; s++) begin
      lk = wide_keys ? key_t'($urandom) : key_t'(16'h2000 + $urandom_range(0, 5));
      if ($urandom_range(0, 1)) mk = HID_MOD_LO + key_t'($urandom_range(0, 7));
      else if (wide_keys) mk = key_t'($urandom);
      else mk = key_t'(16'h3000 + $urandom_range(0, 5));
      if ($urandom_range(0, 7) == 0) mk = lk;
      write_cfg(CFG_IDX_W'(s), {mk, lk});
    end
    key_down.delete();
  endtask

  function automatic key_t pick_key();
    int sel;
    int s;
    sel = $urandom_range(0, 99);
    s = $urandom_range(0, NSLOTS - 1);
    if (sel < 35) return slot_keys[s][15:0];
    if (sel < 70) return slot_keys[s][31:16];
    if (sel < 85) return KC_A + key_t'($urandom_range(0, 3));
    if (sel < 90) return HID_MOD_LO + key_t'($urandom_range(0, 7));
    return key_t'($urandom);
  endfunction

  // Mostly alternating press/release per key, with scans and time jumps
  task automatic send_random_item();
    key_t kc;
    logic pr;
    int   sel;
    sel = $urandom_range(0, 99);
    if (sel < 85) t_ms = t_ms + ms_t'($urandom_range(0, 300));
    else if (sel < 97) t_ms = t_ms + ms_t'($urandom_range(300, 1500));
    else t_ms = ms_t'($urandom);
    if ($urandom_range(0, 99) < 15) begin
      send_item(OP_SCAN, key_t'($urandom), 1'($urandom_range(0, 1)), t_ms);
    end else begin
      kc = pick_key();
      if ($urandom_range(0, 99) < 85) pr = key_down.exists(kc) ? !key_down[kc] : 1'b1;
      else pr = 1'($urandom_range(0, 1));
      key_down[kc] = pr;
      send_item(OP_KEY, kc, pr, t_ms);
    end
  endtask

  // Reset configuration: every keycode field is zero
  task automatic test_reset_state();
    send_item(OP_KEY, 16'h0000, 1'b1, 16'h0000);
    send_item(OP_KEY, 16'hFFFF, 1'b1, 16'h0000);
    send_item(OP_SCAN, 16'h0000, 1'b0, 16'hFFFF);
    wait_results_drained();
  endtask

  task automatic configure_directed_slots();
    write_cfg(CFG_SLOT0_KEYS, {KC_MOD0, KC_LAYER0});
    write_cfg(CFG_SLOT1_KEYS, {KC_MOD1, KC_LAYER1});
    write_cfg(CFG_SLOT2_KEYS, {16'hFFFF, 16'h0000});
    write_cfg(CFG_SLOT3_KEYS, {KC_TWIN, KC_TWIN});
    write_cfg(CFG_SPARE_6, 32'hFFFF_FFFF);
    write_cfg(CFG_SPARE_7, 32'h0000_0001);
    write_cfg(CFG_QUEUED_TIMEOUT, 32'(TIMEOUT_RESET));
    write_cfg(CFG_HOLD_WAIT, 32'(TIMEOUT_RESET));
  endtask

  // Short tap queues the modifier; next press uses it, next release frees it
  task automatic test_oneshot_tap();
    send_item(OP_KEY, KC_LAYER0, 1'b1, 16'd1000);
    send_item(OP_KEY, KC_MOD0, 1'b1, 16'd1000);
    send_item(OP_KEY, KC_MOD0, 1'b0, 16'd1100);
    send_item(OP_KEY, KC_LAYER0, 1'b0, 16'd1150);
    send_item(OP_KEY, KC_A, 1'b1, 16'd1200);
    send_item(OP_KEY, KC_A, 1'b0, 16'd1250);
    wait_results_drained();
  endtask

  // Held past the hold wait: release frees the modifier at once
  task automatic test_long_hold();
    send_item(OP_KEY, KC_LAYER0, 1'b1, 16'd3000);
    send_item(OP_KEY, KC_MOD0, 1'b1, 16'd3000);
    send_item(OP_KEY, KC_MOD0, 1'b0, 16'd3600);
    wait_results_drained();
  endtask

  // Other key activity while down marks the modifier used
  task automatic test_used_release();
    send_item(OP_KEY, KC_MOD0, 1'b1, 16'd4000);
    send_item(OP_KEY, KC_A, 1'b0, 16'd4010);
    send_item(OP_KEY, KC_MOD0, 1'b0, 16'd4050);
    send_item(OP_KEY, KC_LAYER0, 1'b0, 16'd4060);
    wait_results_drained();
  endtask

  // Ignored keys leave the queue alone; scan frees it once elapsed > limit,
  // with the timestamp wrapping through zero
  task automatic test_queued_timeout();
    send_item(OP_KEY, KC_LAYER1, 1'b1, 16'd65300);
    send_item(OP_KEY, KC_MOD1, 1'b1, 16'd65305);
    send_item(OP_KEY, KC_TWIN, 1'b1, 16'd65306);
    send_item(OP_KEY, KC_MOD1, 1'b0, 16'd65310);
    send_item(OP_KEY, KC_LAYER1, 1'b0, 16'd65320);
    send_item(OP_KEY, KC_HID, 1'b1, 16'd65400);
    send_item(OP_SCAN, KC_A, 1'b1, 16'd274);
    send_item(OP_SCAN, 16'hFFFF, 1'b0, 16'd275);
    t_ms = 16'd275;
    wait_results_drained();
  endtask

  task automatic test_random_default();
    load_random_slots(1'b0);
    write_cfg(CFG_QUEUED_TIMEOUT, 32'(TIMEOUT_RESET));
    write_cfg(CFG_HOLD_WAIT, 32'(TIMEOUT_RESET));
    repeat (28) send_random_item();
    // sender holds back until the block has answered everything
    wait_results_drained();
    repeat (27) send_random_item();
    wait_results_drained();
  endtask

  // Zero thresholds, plus a long receiver hold-off that backs up the input
  task automatic test_zero_thresholds();
    load_random_slots(1'b0);
    write_cfg(CFG_QUEUED_TIMEOUT, 32'h0);
    write_cfg(CFG_HOLD_WAIT, 32'h0);
    repeat (10) send_random_item();
    rx_hold_req = 150;
    repeat (50) send_random_item();
    wait_results_drained();
  endtask

  task automatic test_max_thresholds();
    load_random_slots(1'b1);
    write_cfg(CFG_QUEUED_TIMEOUT, 32'h0000_FFFF);
    write_cfg(CFG_HOLD_WAIT, 32'hFFFF_FFFF);
    repeat (45) send_random_item();
    wait_results_drained();
  endtask

  // Final stretch runs at full rate on both sides
  task automatic test_random_thresholds();
    gaps_on = 1'b0;
    load_random_slots(1'b0);
    write_cfg(CFG_QUEUED_TIMEOUT, 32'($urandom_range(0, 1000)));
    write_cfg(CFG_HOLD_WAIT, 32'($urandom_range(0, 1000)));
    repeat (50) send_random_item();
    wait_results_drained();
  endtask

  initial begin
    key_ch.valid = 1'b0;
    key_ch.operation = OP_KEY;
    key_ch.key_code = '0;
    key_ch.is_press = 1'b0;
    key_ch.now_ms = '0;
    res_ch.ready = 1'b0;
    mismatches = 0;
    cycle_cnt = 0;
    rx_stall = 0;
    rx_hold_req = 0;
    gaps_on = 1'b1;
    t_ms = '0;
    tracker_reset();

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_state();
    configure_directed_slots();
    test_oneshot_tap();
    test_long_hold();
    test_used_release();
    test_queued_timeout();
    test_random_default();
    test_zero_thresholds();
    test_max_thresholds();
    test_random_thresholds();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/lomt_pkg.sv
hdl/lomt_if.sv
hdl/lomt_slot_unit.sv
hdl/layer_oneshot_mod_tracker.sv
dv/layer_oneshot_mod_tracker_tb.sv
